@@ hdl/fplm_pkg.sv @@
// ---------------------------------------------------------------------------
// fplm_pkg
// Shared types and constants for the five-plane local maximum check.
// ---------------------------------------------------------------------------
package fplm_pkg;

    localparam int DATA_W  = 32;
    localparam int IDX_W   = 16;
    localparam int PLANE_W = 3;
    localparam int CFG_W   = 17;
    localparam int CNT_W   = 17;
    localparam int NPLANES = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // APB register indexes (byte address / 4)
    localparam logic REG_ROW_LENGTH = 1'b0;
    localparam logic REG_ROW_COUNT  = 1'b1;

    // Neighbor read step for planes 1 and 3
    typedef enum logic [2:0] {
        STEP_SELF,
        STEP_LEFT,
        STEP_RIGHT,
        STEP_UP,
        STEP_DOWN
    } t_step;

    // Controller to datapath commands
    typedef struct packed {
        logic  write;   // store one plane sample
        logic  load;    // capture a candidate
        logic  rd_en;   // issue the reads of one step
        t_step step;
        logic  finish;  // form the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

@@ hdl/fplm_in_if.sv @@
// ---------------------------------------------------------------------------
// fplm_in_if
// Input channel: plane sample writes and candidate checks.
// ---------------------------------------------------------------------------
interface fplm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [fplm_pkg::PLANE_W-1:0]      plane;
    logic [fplm_pkg::IDX_W-1:0]        pixel_index;
    logic signed [fplm_pkg::DATA_W-1:0] sample_value;
    logic                              last_in_list;

    modport source (
        output valid, mode, plane, pixel_index, sample_value, last_in_list,
        input  ready
    );
    modport sink (
        input  valid, mode, plane, pixel_index, sample_value, last_in_list,
        output ready
    );
endinterface

@@ hdl/fplm_out_if.sv @@
// ---------------------------------------------------------------------------
// fplm_out_if
// Output channel: one check result per candidate.
// ---------------------------------------------------------------------------
interface fplm_out_if;
    logic                         valid;
    logic                         ready;
    logic [fplm_pkg::IDX_W-1:0]   result_index;
    logic                         keep;
    logic [fplm_pkg::CNT_W-1:0]   kept_count;

    modport source (
        output valid, result_index, keep, kept_count,
        input  ready
    );
    modport sink (
        input  valid, result_index, keep, kept_count,
        output ready
    );
endinterface

@@ hdl/fplm_ram.sv @@
// ---------------------------------------------------------------------------
// fplm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module fplm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fplm_ctrl.sv @@
// ---------------------------------------------------------------------------
// fplm_ctrl
// Sequencer: accepts items, steps the five neighbor reads, releases results.
// ---------------------------------------------------------------------------
module fplm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_mode,
    output logic           o_ready,
    output fplm_pkg::t_cmd o_cmd,
    input  fplm_pkg::t_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TAIL,
        S_HOLD
    } t_state;

    t_state          r_state;
    fplm_pkg::t_step r_step;
    logic            w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Commands from state
    always_comb begin
        o_cmd        = '0;
        o_cmd.write  = w_accept && !i_mode;
        o_cmd.load   = w_accept && i_mode;
        o_cmd.rd_en  = (r_state == S_READ);
        o_cmd.step   = r_step;
        o_cmd.finish = ((r_state == S_TAIL) || (r_state == S_HOLD)) && i_sts.out_free;
    end

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= fplm_pkg::STEP_SELF;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && i_mode) begin
                        r_state <= S_READ;
                        r_step  <= fplm_pkg::STEP_SELF;
                    end
                end
                S_READ: begin
                    case (r_step)
                        fplm_pkg::STEP_SELF:  r_step <= fplm_pkg::STEP_LEFT;
                        fplm_pkg::STEP_LEFT:  r_step <= fplm_pkg::STEP_RIGHT;
                        fplm_pkg::STEP_RIGHT: r_step <= fplm_pkg::STEP_UP;
                        fplm_pkg::STEP_UP:    r_step <= fplm_pkg::STEP_DOWN;
                        default: begin
                            r_step  <= fplm_pkg::STEP_SELF;
                            r_state <= S_TAIL;
                        end
                    endcase
                end
                S_TAIL: begin
                    r_state <= i_sts.out_free ? S_IDLE : S_HOLD;
                end
                S_HOLD: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_check_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode) |=> (r_state == S_READ && r_step == fplm_pkg::STEP_SELF))
        else $error("check did not start its read sequence");

    a_reads_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_step == fplm_pkg::STEP_DOWN) |=> (r_state == S_TAIL))
        else $error("read sequence did not end after the last step");

    a_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL && !i_sts.out_free) |=> (r_state == S_HOLD && !o_ready))
        else $error("blocked result did not hold the sequencer");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_TAIL) |-> !(o_cmd.write || o_cmd.load))
        else $error("item taken while a check is in progress");
`endif

endmodule

@@ hdl/fplm_dp.sv @@
// ---------------------------------------------------------------------------
// fplm_dp
// Datapath: five plane banks, neighbor addressing, compare and kept count.
// ---------------------------------------------------------------------------
module fplm_dp #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fplm_pkg::t_cmd                     i_cmd,
    output fplm_pkg::t_sts                     o_sts,
    input  logic [fplm_pkg::CFG_W-1:0]         i_row_length,
    input  logic [fplm_pkg::CFG_W-1:0]         i_row_count,
    input  logic [fplm_pkg::PLANE_W-1:0]       i_plane,
    input  logic [fplm_pkg::IDX_W-1:0]         i_pixel_index,
    input  logic signed [fplm_pkg::DATA_W-1:0] i_sample_value,
    input  logic                               i_last_in_list,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fplm_pkg::IDX_W-1:0]         o_result_index,
    output logic                               o_keep,
    output logic [fplm_pkg::CNT_W-1:0]         o_kept_count
);

    localparam int AW     = $clog2(MAX_PIXELS);
    localparam int PW     = $clog2(MAX_PIXELS + 1);
    localparam int CW     = (PW > fplm_pkg::CFG_W + 1) ? PW : fplm_pkg::CFG_W + 1;
    localparam int PROD_W = 2 * fplm_pkg::CFG_W;
    localparam int DW     = fplm_pkg::DATA_W;

    logic [PW-1:0]                r_psize;
    logic [PROD_W-1:0]            w_prod;
    logic [fplm_pkg::IDX_W-1:0]   r_idx;
    logic                         r_last;
    logic                         r_in_plane;
    logic                         r_beaten;
    logic                         r_cmp_vld;
    fplm_pkg::t_step              r_cmp_step;
    logic                         r_cmp_nvld;
    logic [DW-1:0]                r_centre;
    logic [fplm_pkg::CNT_W-1:0]   r_count;
    logic [fplm_pkg::CNT_W-1:0]   n_count;
    logic                         r_out_valid;
    logic [fplm_pkg::IDX_W-1:0]   r_out_index;
    logic                         r_out_keep;
    logic [fplm_pkg::CNT_W-1:0]   r_out_count;

    logic [CW-1:0]  w_idx_ext;
    logic [CW-1:0]  w_wr_ext;
    logic [CW-1:0]  w_off;
    logic [CW-1:0]  w_sum;
    logic [CW-1:0]  w_nb;
    logic           w_nb_vld;
    logic           w_wr_ok;
    logic [DW-1:0]  w_rd [fplm_pkg::NPLANES];
    logic [DW-1:0]  w_centre;
    logic           w_beat;
    logic           w_keep;

    // Plane size: min(row_length * row_count, MAX_PIXELS)
    assign w_prod = PROD_W'(i_row_length) * PROD_W'(i_row_count);
    always_ff @(posedge i_clk) begin
        r_psize <= (w_prod > PROD_W'(MAX_PIXELS)) ? PW'(MAX_PIXELS) : w_prod[PW-1:0];
    end

    // Neighbor address for planes 1 and 3 at the current step
    assign w_idx_ext = CW'(r_idx);
    assign w_off = (i_cmd.step == fplm_pkg::STEP_LEFT || i_cmd.step == fplm_pkg::STEP_RIGHT)
                   ? CW'(1) : CW'(i_row_length);
    assign w_sum = w_idx_ext + w_off;
    always_comb begin
        case (i_cmd.step)
            fplm_pkg::STEP_LEFT, fplm_pkg::STEP_UP: begin
                w_nb     = w_idx_ext - w_off;
                w_nb_vld = (w_idx_ext >= w_off);
            end
            fplm_pkg::STEP_RIGHT, fplm_pkg::STEP_DOWN: begin
                w_nb     = w_sum;
                w_nb_vld = (w_sum < CW'(r_psize));
            end
            default: begin
                w_nb     = w_idx_ext;
                w_nb_vld = 1'b1;
            end
        endcase
    end

    // Sample writes land in the bank named by the plane field
    assign w_wr_ext = CW'(i_pixel_index);
    assign w_wr_ok  = i_cmd.write && (w_wr_ext < CW'(MAX_PIXELS));

    for (genvar b = 0; b < fplm_pkg::NPLANES; b++) begin : g_bank
        logic [AW-1:0] w_raddr;
        if (b == 1 || b == 3) begin : g_nb
            assign w_raddr = w_nb[AW-1:0];
        end else begin : g_self
            assign w_raddr = w_idx_ext[AW-1:0];
        end
        fplm_ram #(
            .WIDTH (DW),
            .DEPTH (MAX_PIXELS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_wr_ok && (i_plane == fplm_pkg::PLANE_W'(b))),
            .i_waddr (w_wr_ext[AW-1:0]),
            .i_wdata (i_sample_value),
            .i_raddr (w_raddr),
            .o_rdata (w_rd[b])
        );
    end

    // Compare read data of the previous step against the center value
    assign w_centre = (r_cmp_step == fplm_pkg::STEP_SELF) ? w_rd[2] : r_centre;
    always_comb begin
        w_beat = r_cmp_nvld && (($signed(w_rd[1]) > $signed(w_centre)) ||
                                ($signed(w_rd[3]) > $signed(w_centre)));
        if (r_cmp_step == fplm_pkg::STEP_SELF) begin
            w_beat = w_beat || ($signed(w_rd[0]) > $signed(w_centre)) ||
                     ($signed(w_rd[4]) > $signed(w_centre));
        end
    end

    // Final decision and saturating count
    assign w_keep  = r_in_plane && !(r_beaten || (r_cmp_vld && w_beat));
    assign n_count = (w_keep && r_count != fplm_pkg::COUNT_MAX) ?
                     r_count + fplm_pkg::CNT_W'(1) : r_count;

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Candidate capture and compare pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_pixel_index;
            r_last <= i_last_in_list;
        end
        if (i_cmd.rd_en && i_cmd.step == fplm_pkg::STEP_SELF) begin
            r_in_plane <= (w_idx_ext < CW'(r_psize));
        end
        if (r_cmp_vld && r_cmp_step == fplm_pkg::STEP_SELF) begin
            r_centre <= w_rd[2];
        end
        r_cmp_step <= i_cmd.step;
        r_cmp_nvld <= w_nb_vld;
        if (i_cmd.finish) begin
            r_out_index <= r_idx;
            r_out_keep  <= w_keep;
            r_out_count <= n_count;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld   <= 1'b0;
            r_beaten    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_beaten <= 1'b0;
            end else if (r_cmp_vld && w_beat) begin
                r_beaten <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count     <= r_last ? '0 : n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_keep         = r_out_keep;
    assign o_kept_count   = r_out_count;

`ifndef SYNTHESIS
    a_outside_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !r_in_plane) |=> (o_out_valid && !o_keep))
        else $error("candidate outside the plane was kept");

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_last) |=> (r_count == '0))
        else $error("kept count not cleared after last candidate");
`endif

endmodule

@@ hdl/five_plane_local_max_check.sv @@
// ---------------------------------------------------------------------------
// five_plane_local_max_check
// 3-D non-maximum suppression of candidates over five stored planes.
// ---------------------------------------------------------------------------
//  channel   direction  protocol     payload
//  i_in      in         valid/ready  mode, plane, pixel_index, sample_value,
//                                    last_in_list
//  o_out     out        valid/ready  result_index, keep, kept_count
//  apb       in         APB write    row_length (0x0), row_count (0x4)
//
//  A sample write leaves the sequencer idle. A check holds off the next accept
//  while it runs: five reads in sequence through the single read port of the
//  plane 1 and plane 3 banks, then a compare in the tail state, before the next accept.
//  The result register parts the output: a full, stalled output holds a
//  finished check until it is taken. Reset is synchronous, active low;
//  plane banks are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module five_plane_local_max_check #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fplm_in_if.sink                      i_in,
    fplm_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [fplm_pkg::CFG_W-1:0] r_row_length;
    logic [fplm_pkg::CFG_W-1:0] r_row_count;
    logic                       w_cfg_wr;
    fplm_pkg::t_cmd             w_cmd;
    fplm_pkg::t_sts             w_sts;

    // Configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= fplm_pkg::CFG_W'(256);
            r_row_count  <= fplm_pkg::CFG_W'(256);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                fplm_pkg::REG_ROW_LENGTH: r_row_length <= pwdata[fplm_pkg::CFG_W-1:0];
                fplm_pkg::REG_ROW_COUNT:  r_row_count  <= pwdata[fplm_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        case (paddr[2])
            fplm_pkg::REG_ROW_LENGTH: prdata = 32'(r_row_length);
            fplm_pkg::REG_ROW_COUNT:  prdata = 32'(r_row_count);
            default:                  prdata = '0;
        endcase
    end

    fplm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_mode  (i_in.mode),
        .o_ready (i_in.ready),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    fplm_dp #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_row_length   (r_row_length),
        .i_row_count    (r_row_count),
        .i_plane        (i_in.plane),
        .i_pixel_index  (i_in.pixel_index),
        .i_sample_value (i_in.sample_value),
        .i_last_in_list (i_in.last_in_list),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_result_index (o_out.result_index),
        .o_keep         (o_out.keep),
        .o_kept_count   (o_out.kept_count)
    );

endmodule

@@ dv/five_plane_local_max_check_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// five_plane_local_max_check_checker
// Watches sample and check transfers, result transfers and register writes.
// Keeps its own copy of the five planes and of the geometry registers,
// works out the keep flag and kept count of every check, and compares each
// result with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module five_plane_local_max_check_checker #(
    parameter int MAX_PIXELS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fplm_in_if          i_in,
    fplm_out_if         i_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_waiting
);

    localparam logic MODE_WRITE   = 1'b0;
    localparam int   CENTRE_PLANE = 2;

    typedef struct packed {
        logic [fplm_pkg::IDX_W-1:0] pix;
        logic                       keep;
        logic [fplm_pkg::CNT_W-1:0] tally;
    } t_check_result;

    logic signed [fplm_pkg::DATA_W-1:0] sample_mem [0:fplm_pkg::NPLANES-1][0:MAX_PIXELS-1];
    logic [fplm_pkg::CFG_W-1:0]         row_len_q;
    logic [fplm_pkg::CFG_W-1:0]         rows_q;
    logic [fplm_pkg::CNT_W-1:0]         kept_tally;
    t_check_result                      expected_results [$];

    // True when the neighbor at pos lies inside the plane and beats the centre
    function automatic bit outranks(int plane, longint pos, longint span,
                                    logic signed [fplm_pkg::DATA_W-1:0] centre);
        if (pos < 0 || pos >= span) return 1'b0;
        return sample_mem[plane][int'(pos)] > centre;
    endfunction

    // Predict one check and advance the running kept count
    function automatic t_check_result judge_candidate(logic [fplm_pkg::IDX_W-1:0] pix,
                                                      logic last);
        longint                             span;
        longint                             pos;
        longint                             stride;
        logic signed [fplm_pkg::DATA_W-1:0] centre;
        logic                               kept;
        t_check_result                      res;
        span = longint'(row_len_q) * longint'(rows_q);
        if (span > MAX_PIXELS) span = MAX_PIXELS;
        pos    = longint'(pix);
        stride = longint'(row_len_q);
        kept   = 1'b0;
        if (pos < span) begin
            centre = sample_mem[CENTRE_PLANE][int'(pos)];
            kept   = !(outranks(0, pos, span, centre) || outranks(4, pos, span, centre));
            // planes 1 and 3: the pixel itself plus its four linear neighbors
            for (int p = 1; p <= 3; p += 2) begin
                if (outranks(p, pos, span, centre) || outranks(p, pos - 1, span, centre)
                    || outranks(p, pos + 1, span, centre)
                    || outranks(p, pos - stride, span, centre)
                    || outranks(p, pos + stride, span, centre)) begin
                    kept = 1'b0;
                end
            end
        end
        if (kept && kept_tally != fplm_pkg::COUNT_MAX) kept_tally++;
        res = '{pix, kept, kept_tally};
        if (last) kept_tally = '0;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_check_result got;
        t_check_result want;
        if (!i_rst_n) begin
            row_len_q    = 17'd256;
            rows_q       = 17'd256;
            kept_tally   = '0;
            expected_results.delete();
            o_fail_count = 0;
            o_waiting    = 0;
        end else begin
            // Track geometry register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[2])
                    fplm_pkg::REG_ROW_LENGTH: row_len_q = pwdata[fplm_pkg::CFG_W-1:0];
                    fplm_pkg::REG_ROW_COUNT:  rows_q    = pwdata[fplm_pkg::CFG_W-1:0];
                    default: ;
                endcase
            end

            // Store samples, predict checks
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1) begin
                if (i_in.mode == MODE_WRITE) begin
                    if (i_in.plane < fplm_pkg::NPLANES && i_in.pixel_index < MAX_PIXELS)
                        sample_mem[i_in.plane][i_in.pixel_index] = i_in.sample_value;
                end else begin
                    expected_results.push_back(
                        judge_candidate(i_in.pixel_index, i_in.last_in_list));
                end
            end

            // Compare each result transfer with the oldest prediction
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                got = '{i_out.result_index, i_out.keep, i_out.kept_count};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: index %0d keep %0b count %0d",
                             $time, got.pix, got.keep, got.tally);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: result mismatch: expected index %0d keep %0b count %0d, %s",
                                 $time, want.pix, want.keep, want.tally, "actual follows");
                        $display("%0t:                  actual   index %0d keep %0b count %0d",
                                 $time, got.pix, got.keep, got.tally);
                        o_fail_count++;
                    end
                end
            end
            o_waiting = expected_results.size();
        end
    end

endmodule

@@ dv/five_plane_local_max_check_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// five_plane_local_max_check_tb
// Drives plane samples, candidate checks and geometry register writes into
// the local maximum check. A short directed run covers plane edges, value
// extremes, ignored planes and candidates outside the plane; random phases
// then plant local peaks, probe stored candidates and mix in noise under
// several geometries and idle patterns. The checker does the comparing.
// ---------------------------------------------------------------------------
module five_plane_local_max_check_tb;

    localparam int   MAX_PIXELS    = 65536;
    localparam int   CYCLE_LIMIT   = 500000;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   HOLD_CYCLES   = 400;
    localparam int   POOL_SPAN     = 24;
    localparam int   CENTRE_PLANE  = 2;
    localparam logic MODE_WRITE    = 1'b0;
    localparam logic MODE_CHECK    = 1'b1;

    localparam logic signed [31:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] SAMPLE_MAX = 32'sh7fff_ffff;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          waiting;

    // Stimulus-side view of the store and geometry
    bit          written_px [0:fplm_pkg::NPLANES-1][0:MAX_PIXELS-1];
    longint      px_count;
    int          row_len_cfg;
    int          pool_base;
    int          items_sent;
    int          send_gap_pct;
    int          recv_stall_pct = 0;
    logic        pressure_go    = 1'b0;

    fplm_in_if  in_ch ();
    fplm_out_if out_ch ();

    five_plane_local_max_check #(.MAX_PIXELS(MAX_PIXELS)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    five_plane_local_max_check_checker #(.MAX_PIXELS(MAX_PIXELS)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // End the run if it stalls
    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("five_plane_local_max_check verification failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_ready
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0:          return SAMPLE_MIN;
            1:          return SAMPLE_MAX;
            2, 3, 4, 5: return 32'(int'($urandom_range(0, 8)) - 4);
            default:    return $urandom;
        endcase
    endfunction

    // Mostly a value at or just under the centre, sometimes anything
    function automatic logic signed [31:0] near_below(logic signed [31:0] centre);
        int unsigned drop;
        if ($urandom_range(0, 7) == 0) return rand_sample();
        drop = $urandom_range(0, 3);
        if (longint'(centre) - longint'(drop) < longint'(SAMPLE_MIN)) return centre;
        return centre - 32'(drop);
    endfunction

    // Plane edges or a small window, so neighborhoods get reused
    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'(px_count - 1);
            default: return 16'((pool_base + $urandom_range(0, POOL_SPAN - 1)) % px_count);
        endcase
    endfunction

    // Offer one item at the falling edge and hold it until the transfer
    task automatic push_item(logic mode, logic [2:0] plane, logic [15:0] pix,
                             logic [31:0] value, logic last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.mode         = mode;
        in_ch.plane        = plane;
        in_ch.pixel_index  = pix;
        in_ch.sample_value = value;
        in_ch.last_in_list = last;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        if (!(mode == MODE_WRITE && plane >= fplm_pkg::NPLANES)) items_sent++;
    endtask

    task automatic write_sample(logic [2:0] plane, logic [15:0] pix,
                                logic signed [31:0] value, logic last);
        push_item(MODE_WRITE, plane, pix, value, last);
        if (plane < fplm_pkg::NPLANES) written_px[plane][pix] = 1'b1;
    endtask

    // Write a random sample where a check would read an unwritten entry
    task automatic fill_gap(int plane, longint pos);
        if (pos >= 0 && pos < px_count && !written_px[plane][int'(pos)])
            write_sample(3'(plane), 16'(pos), rand_sample(), 1'($urandom));
    endtask

    task automatic place_near(int plane, longint pos, logic signed [31:0] centre);
        if (pos >= 0 && pos < px_count)
            write_sample(3'(plane), 16'(pos), near_below(centre), 1'b0);
    endtask

    task automatic cover_neighbours(longint pos);
        if (pos >= px_count) return;
        fill_gap(CENTRE_PLANE, pos);
        fill_gap(0, pos);
        fill_gap(4, pos);
        for (int p = 1; p <= 3; p += 2) begin
            fill_gap(p, pos);
            fill_gap(p, pos - 1);
            fill_gap(p, pos + 1);
            fill_gap(p, pos - row_len_cfg);
            fill_gap(p, pos + row_len_cfg);
        end
    endtask

    // Ignored plane and sample fields carry random bits on a check
    task automatic check_pixel(logic [15:0] pix, logic last);
        cover_neighbours(pix);
        push_item(MODE_CHECK, 3'($urandom), pix, $urandom, last);
    endtask

    // Rewrite a whole neighborhood around a centre value, then check it
    task automatic plant_peak(logic [15:0] pix);
        logic signed [31:0] centre;
        centre = rand_sample();
        write_sample(3'(CENTRE_PLANE), pix, centre, 1'($urandom));
        place_near(0, pix, centre);
        place_near(4, pix, centre);
        for (int p = 1; p <= 3; p += 2) begin
            place_near(p, pix, centre);
            place_near(p, longint'(pix) - 1, centre);
            place_near(p, longint'(pix) + 1, centre);
            place_near(p, longint'(pix) - row_len_cfg, centre);
            place_near(p, longint'(pix) + row_len_cfg, centre);
        end
        check_pixel(pix, $urandom_range(0, 3) == 0);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: write_sample(3'($urandom_range(5, 7)), 16'($urandom), rand_sample(),
                            1'($urandom));
            1: write_sample(3'($urandom_range(0, 4)), 16'($urandom), rand_sample(),
                            1'($urandom));
            2: begin
                if (px_count < MAX_PIXELS)
                    check_pixel(16'($urandom_range(int'(px_count), MAX_PIXELS - 1)),
                                1'($urandom));
                else
                    check_pixel(pick_pixel(), 1'b1);
            end
            3: write_sample(3'($urandom_range(0, 4)), pick_pixel(), rand_sample(), 1'b0);
            default: check_pixel(pick_pixel(), 1'b1);
        endcase
    endtask

    task automatic run_sequence();
        if (px_count == 0) begin
            check_pixel(16'($urandom), $urandom_range(0, 3) == 0);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: plant_peak(pick_pixel());
                4, 5, 6, 7: begin
                    repeat ($urandom_range(1, 4))
                        check_pixel(pick_pixel(), $urandom_range(0, 3) == 0);
                end
                default: send_noise();
            endcase
        end
    endtask

    task automatic run_phase(int quota, int gap_pct, int stall_pct);
        int stop;
        send_gap_pct   = gap_pct;
        recv_stall_pct <= stall_pct;
        pool_base      = (px_count > 0) ? $urandom_range(0, int'(px_count) - 1) : 0;
        stop           = items_sent + quota;
        while (items_sent < stop) run_sequence();
    endtask

    // Wait for every predicted result, then let the block settle
    task automatic drain_results();
        in_ch.valid = 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Setup then access cycle; upper data bits carry junk
    task automatic reg_write(logic sel, int value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {sel, 2'b00};
        pwdata  = {15'($urandom), 17'(value)};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_geometry(int row_len, int rows);
        drain_results();
        reg_write(fplm_pkg::REG_ROW_LENGTH, row_len);
        reg_write(fplm_pkg::REG_ROW_COUNT, rows);
        row_len_cfg = row_len;
        px_count    = longint'(row_len) * longint'(rows);
        if (px_count > MAX_PIXELS) px_count = MAX_PIXELS;
    endtask

    initial begin : stimulus
        logic signed [31:0] seed_px [0:fplm_pkg::NPLANES-1][0:2];
        seed_px = '{'{32'sd0,  SAMPLE_MIN, 32'sd5},
                    '{-32'sd7, SAMPLE_MIN, 32'sd4},
                    '{SAMPLE_MAX, SAMPLE_MIN, 32'sd5},
                    '{32'sd3,  SAMPLE_MIN, 32'sd4},
                    '{SAMPLE_MAX, SAMPLE_MIN, -32'sd1}};

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_WRITE;
        in_ch.plane        = '0;
        in_ch.pixel_index  = '0;
        in_ch.sample_value = '0;
        in_ch.last_in_list = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        items_sent         = 0;
        send_gap_pct       = 0;
        row_len_cfg        = 256;
        px_count           = MAX_PIXELS;
        // Hold reset over several rising edges, release at a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry, no idling
        run_phase(150, 0, 0);

        // Three-pixel plane: edges, value extremes, equal neighbors, ignored planes
        set_geometry(1, 3);
        for (int p = 0; p < fplm_pkg::NPLANES; p++) begin
            for (int i = 0; i < 3; i++)
                write_sample(3'(p), 16'(i), seed_px[p][i], i == 2);
        end
        check_pixel(16'd0, 1'b0);
        check_pixel(16'd1, 1'b0);
        check_pixel(16'd2, 1'b0);
        check_pixel(16'd3, 1'b0);
        check_pixel(16'hffff, 1'b1);
        for (int p = fplm_pkg::NPLANES; p < 8; p++)
            write_sample(3'(p), 16'd2, SAMPLE_MAX, 1'b0);
        check_pixel(16'd2, 1'b0);
        check_pixel(16'd0, 1'b1);

        set_geometry(1, 65536);
        run_phase(240, 67, 0);

        set_geometry(65536, 65536);
        run_phase(240, 0, 67);

        set_geometry(7, 5);
        run_phase(240, 13, 13);

        // Zero row length leaves an empty plane
        set_geometry(0, 3);
        run_phase(20, 0, 0);

        // Long result hold-off while items keep coming
        set_geometry(300, 1);
        pressure_go <= 1'b1;
        run_phase(240, 0, 0);

        set_geometry(65535, 2);
        run_phase(240, 13, 13);

        drain_results();
        if (fail_count == 0) begin
            $display("five_plane_local_max_check verification clean");
        end else begin
            $display("five_plane_local_max_check verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/fplm_pkg.sv
hdl/fplm_in_if.sv
hdl/fplm_out_if.sv
hdl/fplm_ram.sv
hdl/fplm_ctrl.sv
hdl/fplm_dp.sv
hdl/five_plane_local_max_check.sv
dv/five_plane_local_max_check_checker.sv
dv/five_plane_local_max_check_tb.sv
